// ----- src/bcce_pkg.sv -----
// Shared types, register indexes, stage counts and the interpolation helper
// for the cubic Bezier curvature evaluator. No dependencies.
package bcce_pkg;

  // Curve parameter width and the value that means 1.0
  localparam int          PARAM_W = 17;
  localparam logic [16:0] T_ONE   = 17'h10000;

  // Digit stages of the square root and of the curvature divider
  localparam int SQRT_STAGES = 27;
  localparam int DIV_STAGES  = 33;

  typedef logic signed [23:0] coord_t;
  typedef logic [PARAM_W-1:0] param_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CTRL0_X = 3'd0,
    REG_CTRL0_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_CTRL3_X = 3'd6,
    REG_CTRL3_Y = 3'd7
  } reg_idx_e;

  // Four control points, element i is point i
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } ctrl_t;

  // Point and derivatives of one sample
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [26:0] vel_x;
    logic signed [26:0] vel_y;
    logic signed [28:0] acc_x;
    logic signed [28:0] acc_y;
  } kin_t;

  // Front end result handed to the curvature pipe
  typedef struct packed {
    kin_t        kin;
    logic [52:0] s;     // v.v, 24 fraction bits
    logic [54:0] mag;   // |cross|
    logic        neg;   // cross < 0
  } geo_t;

  // a + round_half_up((b - a) * t / 2^16)
  function automatic coord_t lerp(input coord_t a, input coord_t b, input param_t t);
    logic signed [24:0] d;
    logic signed [42:0] m;
    logic signed [42:0] r;
    d = {b[23], b} - {a[23], a};
    m = d * $signed({1'b0, t});
    r = (m + 43'sd32768) >>> 16;
    return a + r[23:0];
  endfunction

endpackage

// ----- src/bcce_front.sv -----
// Bezier front end: point, first and second derivative, then v.v and the
// cross product. Six register stages. Depends on bcce_pkg.
module bcce_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  bcce_pkg::param_t t_in,
  input  bcce_pkg::ctrl_t ctrl,
  output logic            out_vld,
  output bcce_pkg::geo_t  out_geo
);
  import bcce_pkg::*;

  coord_t             pt [2][4];
  logic signed [24:0] dd [2][3];
  logic signed [26:0] ee [2][2];

  logic               v0, v1, v2, v3, v4, v5;
  param_t             t0, u0, t1, u1, t2;
  param_t             t_clamp;

  coord_t             a1 [2][3];
  logic signed [43:0] q01 [2];
  logic signed [43:0] q11 [2];
  logic signed [44:0] as1 [2];

  coord_t             d2 [2];
  coord_t             e2 [2];
  logic signed [60:0] vs2 [2];
  logic signed [28:0] acc2 [2];
  logic signed [47:0] a6 [2];
  logic signed [47:0] ar [2];

  coord_t             pos3 [2];
  logic signed [26:0] vel3 [2];
  logic signed [28:0] acc3 [2];
  logic signed [62:0] v3x [2];
  logic signed [62:0] vr [2];

  kin_t               kin4;
  logic signed [53:0] vxx4, vyy4;
  logic signed [55:0] cxa4, cya4;

  logic signed [54:0] ssum;
  logic signed [56:0] xprod;
  geo_t               geo5;

  // control point differences, per axis (0 = x, 1 = y)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pt[0][i] = ctrl.x[i];
      pt[1][i] = ctrl.y[i];
    end
    for (int a = 0; a < 2; a++) begin
      for (int i = 0; i < 3; i++) begin
        dd[a][i] = {pt[a][i+1][23], pt[a][i+1]} - {pt[a][i][23], pt[a][i]};
      end
      for (int i = 0; i < 2; i++) begin
        ee[a][i] = pt[a][i] - (pt[a][i+1] <<< 1) + pt[a][i+2];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5} <= '0;
    end else if (en) begin
      v0 <= in_vld;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 0: clamp t, form u = 1 - t
  assign t_clamp = (t_in > T_ONE) ? T_ONE : t_in;

  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= t_clamp;
      u0 <= T_ONE - t_clamp;
    end
  end

  // stage 1: first lerp level, first de Casteljau step of velocity, acceleration sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          a1[a][i] <= lerp(pt[a][i], pt[a][i+1], t0);
        end
        q01[a] <= dd[a][0] * $signed({1'b0, u0}) + dd[a][1] * $signed({1'b0, t0});
        q11[a] <= dd[a][1] * $signed({1'b0, u0}) + dd[a][2] * $signed({1'b0, t0});
        as1[a] <= ee[a][0] * $signed({1'b0, u0}) + ee[a][1] * $signed({1'b0, t0});
      end
      t1 <= t0;
      u1 <= u0;
    end
  end

  // stage 2: second lerp level, velocity sum, acceleration scaled and rounded
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      a6[a] = as1[a] * 48'sd6;
      ar[a] = (a6[a] + 48'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        d2[a]   <= lerp(a1[a][0], a1[a][1], t1);
        e2[a]   <= lerp(a1[a][1], a1[a][2], t1);
        vs2[a]  <= q01[a] * $signed({1'b0, u1}) + q11[a] * $signed({1'b0, t1});
        acc2[a] <= ar[a][28:0];
      end
      t2 <= t1;
    end
  end

  // stage 3: final lerp, velocity scaled by 3 and rounded
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      v3x[a] = vs2[a] * 63'sd3 + 63'sd2147483648;
      vr[a]  = v3x[a] >>> 32;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        pos3[a] <= lerp(d2[a], e2[a], t2);
        vel3[a] <= vr[a][26:0];
        acc3[a] <= acc2[a];
      end
    end
  end

  // stage 4: squares and cross terms
  always_ff @(posedge clk) begin
    if (en) begin
      kin4.pos_x <= pos3[0];
      kin4.pos_y <= pos3[1];
      kin4.vel_x <= vel3[0];
      kin4.vel_y <= vel3[1];
      kin4.acc_x <= acc3[0];
      kin4.acc_y <= acc3[1];
      vxx4 <= vel3[0] * vel3[0];
      vyy4 <= vel3[1] * vel3[1];
      cxa4 <= vel3[0] * acc3[1];
      cya4 <= vel3[1] * acc3[0];
    end
  end

  // stage 5: speed squared, cross magnitude and sign
  always_comb begin
    ssum  = vxx4 + vyy4;
    xprod = cxa4 - cya4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo5.kin <= kin4;
      geo5.s   <= ssum[52:0];
      geo5.neg <= xprod[56];
      geo5.mag <= xprod[56] ? 55'(-xprod) : xprod[54:0];
    end
  end

  assign out_vld = v5;
  assign out_geo = geo5;

endmodule

// ----- src/bcce_kappa.sv -----
// Curvature pipe: digit-serial square root, |v|^3 product, digit-serial
// divide and saturation. Payload rides along. Depends on bcce_pkg.
module bcce_kappa (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  bcce_pkg::geo_t     in_geo,
  output logic               out_vld,
  output bcce_pkg::kin_t     out_kin,
  output logic signed [31:0] out_curv,
  output logic               out_cvalid
);
  import bcce_pkg::*;

  typedef struct packed {
    kin_t        kin;
    logic [52:0] s;
    logic [54:0] mag;
    logic        neg;
    logic [28:0] rem;
    logic [26:0] root;
  } sq_t;

  typedef struct packed {
    kin_t        kin;
    logic        neg;
    logic        nz;
    logic        ovf;
    logic [4:0]  mlo;
    logic [79:0] d;
    logic [79:0] rem;
    logic [32:0] q;
  } dv_t;

  sq_t                     sq [SQRT_STAGES];
  logic [SQRT_STAGES-1:0]  sq_v;
  dv_t                     dv [DIV_STAGES];
  logic [DIV_STAGES-1:0]   dv_v;

  logic        v_m, v_d;
  kin_t        kin_m;
  logic        neg_m, nz_m;
  logic [54:0] mag_m;
  logic [53:0] ph_m;
  logic [52:0] pl_m;
  logic [79:0] dval;
  dv_t         dn, dv_d;
  dv_t         last;
  logic        big;

  // square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    sq_t         prev;
    sq_t         nxt;
    logic        pv;
    logic [53:0] sp;
    logic [30:0] rs;
    logic [30:0] tr;
    logic [30:0] df;

    if (j == 0) begin : g_first
      always_comb begin
        prev.kin  = in_geo.kin;
        prev.s    = in_geo.s;
        prev.mag  = in_geo.mag;
        prev.neg  = in_geo.neg;
        prev.rem  = '0;
        prev.root = '0;
      end
      assign pv = in_vld;
    end else begin : g_rest
      assign prev = sq[j-1];
      assign pv   = sq_v[j-1];
    end

    always_comb begin
      sp  = {1'b0, prev.s};
      rs  = {prev.rem, sp[53-2*j -: 2]};
      tr  = {2'b00, prev.root, 2'b01};
      df  = rs - tr;
      nxt = prev;
      if (rs >= tr) begin
        nxt.rem  = df[28:0];
        nxt.root = {prev.root[25:0], 1'b1};
      end else begin
        nxt.rem  = rs[28:0];
        nxt.root = {prev.root[25:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j] <= 1'b0;
      end else if (en) begin
        sq_v[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[j] <= nxt;
      end
    end
  end

  // |v|^3 = s * r, split into two partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
      v_d <= 1'b0;
    end else if (en) begin
      v_m <= sq_v[SQRT_STAGES-1];
      v_d <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kin_m <= sq[SQRT_STAGES-1].kin;
      neg_m <= sq[SQRT_STAGES-1].neg;
      nz_m  <= (sq[SQRT_STAGES-1].s != '0);
      mag_m <= sq[SQRT_STAGES-1].mag;
      ph_m  <= sq[SQRT_STAGES-1].s[52:26] * sq[SQRT_STAGES-1].root;
      pl_m  <= sq[SQRT_STAGES-1].s[25:0] * sq[SQRT_STAGES-1].root;
    end
  end

  // divisor sum, overflow check, initial partial remainder
  always_comb begin
    dval    = {ph_m, 26'd0} + {27'd0, pl_m};
    dn.kin  = kin_m;
    dn.neg  = neg_m;
    dn.nz   = nz_m;
    dn.mlo  = mag_m[4:0];
    dn.d    = dval;
    dn.ovf  = ({30'd0, mag_m[54:5]} >= dval);
    dn.rem  = {30'd0, mag_m[54:5]};
    dn.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d <= dn;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    dv_t         prev;
    dv_t         nxt;
    logic        pv;
    logic        nb;
    logic [80:0] rs;
    logic [80:0] dd;
    logic [80:0] df;

    if (k == 0) begin : g_first
      assign prev = dv_d;
      assign pv   = v_d;
    end else begin : g_rest
      assign prev = dv[k-1];
      assign pv   = dv_v[k-1];
    end

    // numerator is |cross| << 28: only its five low bits feed the top steps
    if (k <= 4) begin : g_nbit
      assign nb = prev.mlo[4-k];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    always_comb begin
      rs  = {prev.rem, nb};
      dd  = {1'b0, prev.d};
      df  = rs - dd;
      nxt = prev;
      if (rs >= dd) begin
        nxt.rem = df[79:0];
        nxt.q   = {prev.q[31:0], 1'b1};
      end else begin
        nxt.rem = rs[79:0];
        nxt.q   = {prev.q[31:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (en) begin
        dv_v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= nxt;
      end
    end
  end

  // sign and saturation
  assign last = dv[DIV_STAGES-1];
  assign big  = last.ovf || last.q[32];

  always_comb begin
    if (!last.nz) begin
      out_curv = '0;
    end else if (last.neg) begin
      if (big || (last.q[31:0] > 32'h8000_0000)) begin
        out_curv = 32'sh8000_0000;
      end else begin
        out_curv = -$signed(last.q[31:0]);
      end
    end else begin
      if (big || last.q[31]) begin
        out_curv = 32'sh7FFF_FFFF;
      end else begin
        out_curv = $signed(last.q[31:0]);
      end
    end
  end

  assign out_vld    = dv_v[DIV_STAGES-1];
  assign out_kin    = last.kin;
  assign out_cvalid = last.nz;

endmodule

// ----- src/cubic_bezier_curvature_eval.sv -----
// Top level of the cubic Bezier evaluator: control point registers, front
// end, curvature pipe and output register. Depends on bcce_pkg, bcce_front, bcce_kappa.
//
//  port group  | dir | beat contents
//  ------------+-----+----------------------------------------------------------
//  s_t*        | in  | tdata: curve_param (t, Q1.16, values above 1.0 clamp)
//  m_t*        | out | tdata: pos, vel, acc (x then y), curvature; tuser: curvature_valid
//  cfg_*       | in  | write of one control point coordinate, signed Q12.12
//
// One beat enters per cycle while the output is not stalled.
// Depth: front end, 27 square root and 33 divide digit stages, product, divisor, output.
// A result held at the output (m_tvalid high, m_tready low) freezes the whole
// pipeline and drops s_tready; nothing is lost or repeated.
// Synchronous reset clears the control points to zero and empties the pipeline.
module cubic_bezier_curvature_eval (
  input  logic         clk,
  input  logic         rst,
  // curve_param [16:0]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,
  // pos_x [23:0], pos_y [47:24], vel_x [74:48], vel_y [101:75],
  // acc_x [130:102], acc_y [159:131], curvature [191:160]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,
  // curvature_valid [0]
  output logic [0:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [23:0]  cfg_data
);
  import bcce_pkg::*;

  ctrl_t              ctrl;
  logic               en;
  logic               f_vld;
  geo_t               f_geo;
  logic               k_vld;
  kin_t               k_kin;
  logic signed [31:0] k_curv;
  logic               k_cvalid;

  // control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (cfg_we) begin
      case (reg_idx_e'(cfg_addr))
        REG_CTRL0_X: ctrl.x[0] <= cfg_data;
        REG_CTRL0_Y: ctrl.y[0] <= cfg_data;
        REG_CTRL1_X: ctrl.x[1] <= cfg_data;
        REG_CTRL1_Y: ctrl.y[1] <= cfg_data;
        REG_CTRL2_X: ctrl.x[2] <= cfg_data;
        REG_CTRL2_Y: ctrl.y[2] <= cfg_data;
        REG_CTRL3_X: ctrl.x[3] <= cfg_data;
        REG_CTRL3_Y: ctrl.y[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves unless the output beat is stuck
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  bcce_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_tvalid),
    .t_in    (s_tdata[PARAM_W-1:0]),
    .ctrl    (ctrl),
    .out_vld (f_vld),
    .out_geo (f_geo)
  );

  bcce_kappa u_kappa (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (f_vld),
    .in_geo     (f_geo),
    .out_vld    (k_vld),
    .out_kin    (k_kin),
    .out_curv   (k_curv),
    .out_cvalid (k_cvalid)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {k_curv, k_kin.acc_y, k_kin.acc_x, k_kin.vel_y, k_kin.vel_x,
                  k_kin.pos_y, k_kin.pos_x};
      m_tuser <= k_cvalid;
    end
  end

endmodule

// ----- src/bcce_checker.sv -----
// Port-level checks for the cubic Bezier evaluator, bound to the top level.
// Depends on cubic_bezier_curvature_eval.
module bcce_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata,
  input logic [0:0]   m_tuser
);

  // input side stalls exactly when an output beat is stuck
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not track output stall");

  // a stuck output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // zero speed gives zero curvature
  a_zero_curv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[191:160] == 32'd0)
    else $error("curvature nonzero with curvature_valid low");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind cubic_bezier_curvature_eval bcce_checker u_bcce_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
